@@ rtl/sdnl_pkg.sv @@
`timescale 1ns / 1ps
// Package for the signed decimal number lexer: widths, symbol kinds,
// character codes and the result record type. No dependencies.
package sdnl_pkg;

   localparam int MANT_BITS = 48;
   localparam int ID_BITS   = 16;
   localparam int FRAC_BITS = 5;

   localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

   // symbol kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_STRING = 2'd1;
   localparam logic [1:0] KIND_BLANK  = 2'd2;
   localparam logic [1:0] KIND_OTHER  = 2'd3;

   // character codes
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   // result type codes
   localparam logic OUT_PASS   = 1'b0;
   localparam logic OUT_NUMBER = 1'b1;

   typedef struct packed {
      logic                 out_type;
      logic [1:0]           pass_kind;
      logic [7:0]           pass_char;
      logic [ID_BITS-1:0]   pass_id;
      logic                 is_negative;
      logic [MANT_BITS-1:0] mantissa;
      logic [FRAC_BITS-1:0] frac_digits;
      logic                 overflow;
      logic                 stream_end;
      logic                 syntax_error;
   } sdnl_result_type;

endpackage

@@ rtl/sdnl_core.sv @@
`timescale 1ns / 1ps
// Lexer state and per-symbol decode: turns one accepted symbol into up to
// two result records. Depends on sdnl_pkg.
module sdnl_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_accept,
   input  logic [1:0]                          sym_kind,
   input  logic [7:0]                          sym_char,
   input  logic [sdnl_pkg::ID_BITS-1:0]        sym_id,
   input  logic                                end_of_input,
   output sdnl_pkg::sdnl_result_type [1:0]     results,
   output logic [1:0]                          result_count
);
   import sdnl_pkg::*;

   localparam logic [2:0] MODE_OUT  = 3'd0;
   localparam logic [2:0] MODE_PRE  = 3'd1;
   localparam logic [2:0] MODE_SIGN = 3'd2;
   localparam logic [2:0] MODE_INT  = 3'd3;
   localparam logic [2:0] MODE_FRAC = 3'd4;

   logic [2:0]           mode_ff,  mode_in;
   logic [ID_BITS-1:0]   held_ff,  held_in;
   logic                 neg_ff,   neg_in;
   logic [MANT_BITS-1:0] accum_ff, accum_in;
   logic [FRAC_BITS-1:0] frac_ff,  frac_in;
   logic                 sat_ff,   sat_in;

   logic [7:0]           ch;
   logic [3:0]           digit_off;
   logic                 is_char, is_digit, is_bracket, is_sep;
   logic [2:0]           next_mode;
   logic [MANT_BITS-1:0] acc_src;
   logic [MANT_BITS+3:0] mac_wide;
   logic                 mac_sat;
   logic [MANT_BITS-1:0] mac_val;
   logic                 err;
   sdnl_result_type      pass_r, minus_r, num_r, flush_r;

   always_comb begin
      is_char    = (sym_kind == KIND_CHAR);
      ch         = is_char ? sym_char : 8'd0;
      is_digit   = is_char && (ch inside {[CHAR_ZERO:CHAR_NINE]});
      is_bracket = is_char && (ch inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACK,
                                          CHAR_RBRACK, CHAR_LBRACE, CHAR_RBRACE});
      is_sep     = (sym_kind == KIND_STRING) || (sym_kind == KIND_BLANK) || is_bracket;
      next_mode  = is_sep ? MODE_PRE : MODE_OUT;
      digit_off  = 4'(ch - CHAR_ZERO);

      // acc*10 + digit; a fresh number starts from zero
      acc_src  = (mode_ff == MODE_INT || mode_ff == MODE_FRAC) ? accum_ff : '0;
      mac_wide = ({4'd0, acc_src} << 3) + ({4'd0, acc_src} << 1)
               + {{MANT_BITS{1'b0}}, digit_off};
      mac_sat  = |mac_wide[MANT_BITS+3:MANT_BITS];
      mac_val  = mac_sat ? '1 : mac_wide[MANT_BITS-1:0];

      pass_r           = '0;
      pass_r.out_type  = OUT_PASS;
      pass_r.pass_kind = sym_kind;
      pass_r.pass_char = ch;
      pass_r.pass_id   = sym_id;

      minus_r           = '0;
      minus_r.out_type  = OUT_PASS;
      minus_r.pass_kind = KIND_CHAR;
      minus_r.pass_char = CHAR_MINUS;
      minus_r.pass_id   = held_ff;

      num_r             = '0;
      num_r.out_type    = OUT_NUMBER;
      num_r.is_negative = neg_ff;
      num_r.mantissa    = accum_ff;
      num_r.frac_digits = frac_ff;
      num_r.overflow    = sat_ff;

      mode_in      = mode_ff;
      held_in      = held_ff;
      neg_in       = neg_ff;
      accum_in     = accum_ff;
      frac_in      = frac_ff;
      sat_in       = sat_ff;
      results      = '0;
      result_count = 2'd0;
      err          = 1'b0;
      flush_r      = '0;

      case (mode_ff)
         MODE_PRE: begin
            if (is_char && ch == CHAR_MINUS) begin
               held_in = sym_id;
               neg_in  = 1'b1;
               mode_in = MODE_SIGN;
            end else if (is_digit) begin
               neg_in   = 1'b0;
               accum_in = mac_val;
               frac_in  = '0;
               sat_in   = 1'b0;
               mode_in  = MODE_INT;
            end else begin
               results[0]   = pass_r;
               result_count = 2'd1;
               mode_in      = next_mode;
            end
         end
         MODE_SIGN: begin
            if (is_digit) begin
               accum_in = mac_val;
               frac_in  = '0;
               sat_in   = 1'b0;
               mode_in  = MODE_INT;
            end else begin
               results[0]   = minus_r;
               results[1]   = pass_r;
               result_count = 2'd2;
               neg_in       = 1'b0;
               mode_in      = next_mode;
            end
         end
         MODE_INT, MODE_FRAC: begin
            if (is_digit) begin
               if (mode_ff == MODE_FRAC && frac_ff == FRAC_MAX) begin
                  sat_in = 1'b1;
               end else begin
                  accum_in = mac_val;
                  sat_in   = sat_ff | mac_sat;
                  if (mode_ff == MODE_FRAC) begin
                     frac_in = frac_ff + 1'b1;
                  end
               end
            end else if (mode_ff == MODE_INT && is_char && ch == CHAR_POINT) begin
               mode_in = MODE_FRAC;
            end else begin
               results[0]   = num_r;
               results[1]   = pass_r;
               result_count = 2'd2;
               neg_in       = 1'b0;
               accum_in     = '0;
               frac_in      = '0;
               sat_in       = 1'b0;
               mode_in      = next_mode;
            end
         end
         default: begin
            results[0]   = pass_r;
            result_count = 2'd1;
            mode_in      = next_mode;
         end
      endcase

      if (end_of_input) begin
         // flush only happens when the symbol itself was absorbed
         if (mode_in == MODE_SIGN) begin
            flush_r           = '0;
            flush_r.out_type  = OUT_PASS;
            flush_r.pass_kind = KIND_CHAR;
            flush_r.pass_char = CHAR_MINUS;
            flush_r.pass_id   = held_in;
            results[0]        = flush_r;
            result_count      = 2'd1;
         end else if (mode_in == MODE_INT || mode_in == MODE_FRAC) begin
            err                 = (mode_in == MODE_FRAC) && (frac_in == '0);
            flush_r             = '0;
            flush_r.out_type    = OUT_NUMBER;
            flush_r.is_negative = neg_in;
            flush_r.mantissa    = accum_in;
            flush_r.frac_digits = frac_in;
            flush_r.overflow    = sat_in;
            results[0]          = flush_r;
            result_count        = 2'd1;
         end
         if (result_count == 2'd2) begin
            results[1].stream_end   = 1'b1;
            results[1].syntax_error = err;
         end else begin
            results[0].stream_end   = 1'b1;
            results[0].syntax_error = err;
         end
         mode_in  = MODE_OUT;
         held_in  = '0;
         neg_in   = 1'b0;
         accum_in = '0;
         frac_in  = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OUT;
         held_ff  <= '0;
         neg_ff   <= 1'b0;
         accum_ff <= '0;
         frac_ff  <= '0;
         sat_ff   <= 1'b0;
      end else if (item_accept) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         neg_ff   <= neg_in;
         accum_ff <= accum_in;
         frac_ff  <= frac_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

@@ rtl/signed_decimal_number_lexer_top.sv @@
`timescale 1ns / 1ps
// Top level of the signed decimal number lexer: lexer core plus a
// three-entry result queue. Depends on sdnl_pkg and sdnl_core.
//
// Usage:
//  - req_ channel carries one symbol per transaction (kind, character,
//    identifier, end_of_input). rsp_ channel carries one result per
//    transaction: a passed symbol or a number token.
//  - A symbol is decoded in the cycle it is accepted; its results are
//    written to the queue and rsp_valid rises on the next cycle.
//  - A symbol gives 0, 1 or 2 results. The queue holds three results and
//    req_stall is high while two or more are waiting, so while rsp_stall is
//    low symbols giving one result flow at one per cycle and a symbol giving
//    two results hands them one at a time to the single result port.
//  - The last result of a stream carries stream_end, with syntax_error set
//    when the stream ended on a point with no digit after it; the lexer then
//    returns to its reset state for the next stream.
//  - When the receiver raises rsp_stall the head result holds; once two
//    results wait the input stalls, nothing is dropped.
//  - Synchronous reset empties the queue and clears the lexer state.
module signed_decimal_number_lexer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_sym_kind,
   input  logic [7:0]                           req_sym_char,
   input  logic [sdnl_pkg::ID_BITS-1:0]         req_sym_id,
   input  logic                                 req_end_of_input,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_out_type,
   output logic [1:0]                           rsp_pass_kind,
   output logic [7:0]                           rsp_pass_char,
   output logic [sdnl_pkg::ID_BITS-1:0]         rsp_pass_id,
   output logic                                 rsp_is_negative,
   output logic [sdnl_pkg::MANT_BITS-1:0]       rsp_mantissa,
   output logic [sdnl_pkg::FRAC_BITS-1:0]       rsp_frac_digits,
   output logic                                 rsp_overflow,
   output logic                                 rsp_stream_end,
   output logic                                 rsp_syntax_error
);
   import sdnl_pkg::*;

   localparam int QDEPTH = 3;

   sdnl_result_type [1:0] core_results;
   logic [1:0]            core_count;
   logic                  item_accept;
   logic                  pop;

   sdnl_result_type entry_ff [QDEPTH];
   logic [1:0]      wr_ptr_ff, wr_ptr_in;
   logic [1:0]      rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff,  count_in;
   logic [1:0]      wr_next;
   logic [2:0]      ptr_gap;
   sdnl_result_type head;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_stall   = (count_ff > 2'd1);
   assign item_accept = req_valid && !req_stall;
   assign rsp_valid   = (count_ff != 2'd0);
   assign pop         = rsp_valid && !rsp_stall;

   sdnl_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .sym_kind     (req_sym_kind),
      .sym_char     (req_sym_char),
      .sym_id       (req_sym_id),
      .end_of_input (req_end_of_input),
      .results      (core_results),
      .result_count (core_count)
   );

   always_comb begin
      wr_next   = ptr_inc(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (item_accept) begin
         case (core_count)
            2'd1:    wr_ptr_in = wr_next;
            2'd2:    wr_ptr_in = ptr_inc(wr_next);
            default: wr_ptr_in = wr_ptr_ff;
         endcase
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (item_accept ? core_count : 2'd0) - {1'b0, pop};
      head      = entry_ff[rd_ptr_ff];
      ptr_gap   = {1'b0, wr_ptr_ff} + 3'(QDEPTH) - {1'b0, rd_ptr_ff};
      if (ptr_gap >= 3'(QDEPTH)) begin
         ptr_gap = ptr_gap - 3'(QDEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept && core_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= core_results[0];
      end
      if (item_accept && core_count == 2'd2) begin
         entry_ff[wr_next] <= core_results[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_out_type     = head.out_type;
   assign rsp_pass_kind    = head.pass_kind;
   assign rsp_pass_char    = head.pass_char;
   assign rsp_pass_id      = head.pass_id;
   assign rsp_is_negative  = head.is_negative;
   assign rsp_mantissa     = head.mantissa;
   assign rsp_frac_digits  = head.frac_digits;
   assign rsp_overflow     = head.overflow;
   assign rsp_stream_end   = head.stream_end;
   assign rsp_syntax_error = head.syntax_error;

   // the last symbol of a stream always leaves at least one result queued
   a_eoi_gives_result : assert property (@(posedge clock) disable iff (reset)
      item_accept && req_end_of_input |=> count_ff != 2'd0)
      else $error("end of stream produced no result");

   // pointers stay within the queue depth
   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff != 2'd3 && wr_ptr_ff != 2'd3)
      else $error("queue pointer out of range");

   // occupancy agrees with the pointer distance
   a_count_ptrs : assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd3 && ptr_gap == 3'd0) || ptr_gap == {1'b0, count_ff})
      else $error("queue count and pointers disagree");

   // the queue never has to take more than it has room for
   a_no_overfill : assert property (@(posedge clock) disable iff (reset)
      item_accept |-> {1'b0, count_ff} + {1'b0, core_count} <= 3'd3)
      else $error("result queue overfilled");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for signed_decimal_number_lexer_top: a directed table, then random symbol
// streams under changing stall patterns, checked by a lexer model kept here.
// Depends on sdnl_pkg and the RTL of the lexer only.
module tb_top;
   import sdnl_pkg::*;

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS      = 40;
   localparam logic [63:0] MANT_LIMIT = (64'd1 << MANT_BITS) - 64'd1;

   typedef enum logic [2:0] {
      PH_IDLE, PH_AFTER_SEP, PH_MINUS, PH_INTEGER, PH_FRACTION
   } lex_phase_type;

   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         ch;
      logic [ID_BITS-1:0] id;
      logic               eoi;
      bit                 by_hand;
      sdnl_result_type    hand;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_sym_kind = '0;
   logic [7:0]           req_sym_char = '0;
   logic [ID_BITS-1:0]   req_sym_id = '0;
   logic                 req_end_of_input = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_out_type;
   logic [1:0]           rsp_pass_kind;
   logic [7:0]           rsp_pass_char;
   logic [ID_BITS-1:0]   rsp_pass_id;
   logic                 rsp_is_negative;
   logic [MANT_BITS-1:0] rsp_mantissa;
   logic [FRAC_BITS-1:0] rsp_frac_digits;
   logic                 rsp_overflow;
   logic                 rsp_stream_end;
   logic                 rsp_syntax_error;

   // model state
   lex_phase_type        lexer_phase = PH_IDLE;
   logic [ID_BITS-1:0]   minus_id = '0;
   logic                 number_negative = 1'b0;
   logic [63:0]          number_value = '0;
   logic [FRAC_BITS-1:0] fraction_count = '0;
   logic                 number_saturated = 1'b0;

   sdnl_result_type      step_results[$];
   sdnl_result_type      expected_results[$];
   stim_row_type         directed_table[$];

   // hand-typed expectation travelling with the current transaction
   bit                   hand_checked = 1'b0;
   sdnl_result_type      hand_expect = '0;

   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   bit                   hold_request = 1'b0;
   int                   hold_left = 0;
   int                   symbols_sent = 0;
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;

   signed_decimal_number_lexer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sym_kind     (req_sym_kind),
      .req_sym_char     (req_sym_char),
      .req_sym_id       (req_sym_id),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_type     (rsp_out_type),
      .rsp_pass_kind    (rsp_pass_kind),
      .rsp_pass_char    (rsp_pass_char),
      .rsp_pass_id      (rsp_pass_id),
      .rsp_is_negative  (rsp_is_negative),
      .rsp_mantissa     (rsp_mantissa),
      .rsp_frac_digits  (rsp_frac_digits),
      .rsp_overflow     (rsp_overflow),
      .rsp_stream_end   (rsp_stream_end),
      .rsp_syntax_error (rsp_syntax_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic sdnl_result_type make_result(logic typ, logic [1:0] kind,
         logic [7:0] ch, logic [ID_BITS-1:0] id, logic neg, logic [MANT_BITS-1:0] mant,
         logic [FRAC_BITS-1:0] frac, logic ovf, logic se, logic err);
      sdnl_result_type r;
      r.out_type     = typ;
      r.pass_kind    = kind;
      r.pass_char    = ch;
      r.pass_id      = id;
      r.is_negative  = neg;
      r.mantissa     = mant;
      r.frac_digits  = frac;
      r.overflow     = ovf;
      r.stream_end   = se;
      r.syntax_error = err;
      return r;
   endfunction

   function automatic stim_row_type stim_row(logic [1:0] kind, logic [7:0] ch,
         logic [ID_BITS-1:0] id, logic eoi, bit by_hand, sdnl_result_type hand);
      stim_row_type r;
      r.kind    = kind;
      r.ch      = ch;
      r.id      = id;
      r.eoi     = eoi;
      r.by_hand = by_hand;
      r.hand    = hand;
      return r;
   endfunction

   function automatic void table_row(logic [1:0] kind, logic [7:0] ch,
         logic [ID_BITS-1:0] id, logic eoi, bit by_hand, sdnl_result_type hand);
      directed_table = {directed_table, stim_row(kind, ch, id, eoi, by_hand, hand)};
   endfunction

   // ---------------------------------------------------------------- lexer model

   function automatic void add_decimal_digit(logic [3:0] d);
      if (number_value > (MANT_LIMIT - d) / 64'd10) begin
         number_value     = MANT_LIMIT;
         number_saturated = 1'b1;
      end else begin
         number_value = number_value * 64'd10 + d;
      end
   endfunction

   function automatic void open_number(logic [3:0] d);
      number_value     = '0;
      fraction_count   = '0;
      number_saturated = 1'b0;
      add_decimal_digit(d);
   endfunction

   function automatic void close_number();
      // kind, character and id read as zero on a number token
      step_results = {step_results, make_result(OUT_NUMBER, KIND_CHAR, 8'h00, '0,
         number_negative, number_value[MANT_BITS-1:0], fraction_count, number_saturated,
         1'b0, 1'b0)};
      number_negative  = 1'b0;
      number_value     = '0;
      fraction_count   = '0;
      number_saturated = 1'b0;
   endfunction

   function automatic void release_minus();
      step_results = {step_results, make_result(OUT_PASS, KIND_CHAR, CHAR_MINUS, minus_id,
         1'b0, '0, '0, 1'b0, 1'b0, 1'b0)};
      number_negative = 1'b0;
   endfunction

   function automatic void lex_symbol(logic [1:0] kind, logic [7:0] ch_in,
         logic [ID_BITS-1:0] id, logic eoi);
      logic [7:0]      ch;
      logic            is_char;
      logic            is_digit;
      logic            is_sep;
      logic            bad_point;
      lex_phase_type   follow;
      sdnl_result_type passed;
      sdnl_result_type last;
      is_char  = kind == KIND_CHAR;
      ch       = is_char ? ch_in : 8'h00;
      is_digit = is_char && ch >= CHAR_ZERO && ch <= CHAR_NINE;
      is_sep   = kind == KIND_STRING || kind == KIND_BLANK ||
                 (is_char && (ch == CHAR_LPAREN || ch == CHAR_RPAREN ||
                              ch == CHAR_LBRACK || ch == CHAR_RBRACK ||
                              ch == CHAR_LBRACE || ch == CHAR_RBRACE));
      follow   = is_sep ? PH_AFTER_SEP : PH_IDLE;
      passed   = make_result(OUT_PASS, kind, ch, id, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0);
      case (lexer_phase)
         PH_AFTER_SEP: begin
            if (is_char && ch == CHAR_MINUS) begin
               minus_id        = id;
               number_negative = 1'b1;
               lexer_phase     = PH_MINUS;
            end else if (is_digit) begin
               number_negative = 1'b0;
               open_number(4'(ch - CHAR_ZERO));
               lexer_phase = PH_INTEGER;
            end else begin
               step_results = {step_results, passed};
               lexer_phase = follow;
            end
         end
         PH_MINUS: begin
            if (is_digit) begin
               open_number(4'(ch - CHAR_ZERO));
               lexer_phase = PH_INTEGER;
            end else begin
               // lone minus: both it and the symbol after it go through
               release_minus();
               step_results = {step_results, passed};
               lexer_phase = follow;
            end
         end
         PH_INTEGER: begin
            if (is_digit) begin
               add_decimal_digit(4'(ch - CHAR_ZERO));
            end else if (is_char && ch == CHAR_POINT) begin
               lexer_phase = PH_FRACTION;
            end else begin
               close_number();
               step_results = {step_results, passed};
               lexer_phase = follow;
            end
         end
         PH_FRACTION: begin
            if (is_digit) begin
               if (fraction_count == FRAC_MAX) begin
                  number_saturated = 1'b1;
               end else begin
                  add_decimal_digit(4'(ch - CHAR_ZERO));
                  fraction_count++;
               end
            end else begin
               close_number();
               step_results = {step_results, passed};
               lexer_phase = follow;
            end
         end
         default: begin
            step_results = {step_results, passed};
            lexer_phase = follow;
         end
      endcase

      if (eoi) begin
         bad_point = 1'b0;
         if (lexer_phase == PH_MINUS) begin
            release_minus();
         end else if (lexer_phase == PH_INTEGER || lexer_phase == PH_FRACTION) begin
            bad_point = lexer_phase == PH_FRACTION && fraction_count == '0;
            close_number();
         end
         if (step_results.size() != 0) begin
            last              = step_results.pop_back();
            last.stream_end   = 1'b1;
            last.syntax_error = bad_point;
            step_results = {step_results, last};
         end
         lexer_phase      = PH_IDLE;
         minus_id         = '0;
         number_negative  = 1'b0;
         number_value     = '0;
         fraction_count   = '0;
         number_saturated = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("tb_top: mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_result(sdnl_result_type got, sdnl_result_type want);
      if (got.out_type !== want.out_type)
         report_mismatch($sformatf("out_type %0h, want %0h", got.out_type, want.out_type));
      if (got.pass_kind !== want.pass_kind)
         report_mismatch($sformatf("pass_kind %0h, want %0h", got.pass_kind, want.pass_kind));
      if (got.pass_char !== want.pass_char)
         report_mismatch($sformatf("pass_char %0h, want %0h", got.pass_char, want.pass_char));
      if (got.pass_id !== want.pass_id)
         report_mismatch($sformatf("pass_id %0h, want %0h", got.pass_id, want.pass_id));
      if (got.is_negative !== want.is_negative)
         report_mismatch($sformatf("is_negative %0h, want %0h",
            got.is_negative, want.is_negative));
      if (got.mantissa !== want.mantissa)
         report_mismatch($sformatf("mantissa %0d, want %0d", got.mantissa, want.mantissa));
      if (got.frac_digits !== want.frac_digits)
         report_mismatch($sformatf("frac_digits %0d, want %0d",
            got.frac_digits, want.frac_digits));
      if (got.overflow !== want.overflow)
         report_mismatch($sformatf("overflow %0h, want %0h", got.overflow, want.overflow));
      if (got.stream_end !== want.stream_end)
         report_mismatch($sformatf("stream_end %0h, want %0h",
            got.stream_end, want.stream_end));
      if (got.syntax_error !== want.syntax_error)
         report_mismatch($sformatf("syntax_error %0h, want %0h",
            got.syntax_error, want.syntax_error));
   endtask

   always @(posedge clock) begin : monitor
      sdnl_result_type got;
      bit              rsp_taken;
      bit              req_taken;
      if (!reset) begin
         rsp_taken = rsp_valid && !rsp_stall;
         req_taken = req_valid && !req_stall;
         // results first, so a fresh symbol can never cover for a stray result
         if (rsp_taken) begin
            got = {rsp_out_type, rsp_pass_kind, rsp_pass_char, rsp_pass_id, rsp_is_negative,
                   rsp_mantissa, rsp_frac_digits, rsp_overflow, rsp_stream_end,
                   rsp_syntax_error};
            if (expected_results.size() == 0)
               report_mismatch("result transaction with nothing expected");
            else
               compare_result(got, expected_results.pop_front());
         end
         if (req_taken) begin
            step_results.delete();
            lex_symbol(req_sym_kind, req_sym_char, req_sym_id, req_end_of_input);
            if (hand_checked)
               expected_results = {expected_results, hand_expect};
            else
               expected_results = {expected_results, step_results};
         end
         if (rsp_taken || req_taken) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("tb_top: watchdog expired, %0d results outstanding",
                  expected_results.size());
               $display("tb_top: FAIL");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- sender

   // called and returns at a falling edge
   task automatic send_symbol(logic [1:0] kind, logic [7:0] ch, logic [ID_BITS-1:0] id,
         logic eoi, bit by_hand, sdnl_result_type hand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sym_kind     <= kind;
      req_sym_char     <= ch;
      req_sym_id       <= id;
      req_end_of_input <= eoi;
      hand_checked     <= by_hand;
      hand_expect      <= hand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      symbols_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(logic [1:0] kind, logic [7:0] ch, logic eoi);
      logic [ID_BITS-1:0] id;
      id = ID_BITS'($urandom());
      send_symbol(kind, ch, id, eoi, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] random_bracket();
      case ($urandom_range(5))
         0:       return CHAR_LPAREN;
         1:       return CHAR_RPAREN;
         2:       return CHAR_LBRACK;
         3:       return CHAR_RBRACK;
         4:       return CHAR_LBRACE;
         default: return CHAR_RBRACE;
      endcase
   endfunction

   function automatic logic [7:0] random_nondigit();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         c = c + 8'd16;
      return c;
   endfunction

   function automatic logic [7:0] random_noise_char();
      case ($urandom_range(5))
         0:       return CHAR_MINUS;
         1:       return CHAR_POINT;
         2:       return CHAR_ZERO + 8'($urandom_range(9));
         3:       return random_bracket();
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_separator();
      case ($urandom_range(2))
         0:       send_plain(KIND_STRING, random_noise_char(), 1'b0);
         1:       send_plain(KIND_BLANK, random_noise_char(), 1'b0);
         default: send_plain(KIND_CHAR, random_bracket(), 1'b0);
      endcase
   endtask

   task automatic send_digits(int count);
      repeat (count) send_plain(KIND_CHAR, CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
   endtask

   task automatic send_terminator();
      logic [1:0] kind;
      kind = 2'($urandom_range(3));
      send_plain(kind, random_nondigit(), $urandom_range(9) == 0);
   endtask

   task automatic send_random_segment();
      int pick;
      int int_len;
      int frac_len;
      pick     = $urandom_range(99);
      // long runs now and then to saturate the mantissa or the fraction count
      int_len  = ($urandom_range(24) == 0) ? $urandom_range(20, 14) : $urandom_range(6, 1);
      frac_len = ($urandom_range(29) == 0) ? $urandom_range(36, 30) : $urandom_range(5, 1);
      if (pick < 60) begin
         send_separator();
         if ($urandom_range(1)) send_plain(KIND_CHAR, CHAR_MINUS, 1'b0);
         send_digits(int_len);
         if ($urandom_range(99) < 60) begin
            send_plain(KIND_CHAR, CHAR_POINT, 1'b0);
            send_digits(frac_len);
         end
         send_terminator();
      end else if (pick < 75) begin
         send_separator();
         case ($urandom_range(4))
            0: begin
               send_plain(KIND_CHAR, CHAR_MINUS, 1'b0);
               send_terminator();
            end
            1: begin
               send_digits(int_len);
               send_plain(KIND_CHAR, CHAR_POINT, 1'b0);
               send_terminator();
            end
            2: begin
               send_digits(int_len);
               send_plain(KIND_CHAR, CHAR_POINT, 1'b0);
               send_digits(frac_len);
               send_plain(KIND_CHAR, CHAR_POINT, $urandom_range(3) == 0);
            end
            3: begin
               send_plain(KIND_CHAR, CHAR_MINUS, 1'b1);
            end
            default: begin
               send_digits(int_len);
               send_plain(KIND_CHAR, CHAR_POINT, 1'b1);
            end
         endcase
      end else begin
         repeat ($urandom_range(4, 1))
            send_plain(2'($urandom_range(3)), random_noise_char(), $urandom_range(39) == 0);
      end
   endtask

   initial begin
      // unlisted results come from the model; hand-typed ones are single results
      table_row(KIND_CHAR, 8'h41, 16'h0000, 1'b0, 1'b1,
         make_result(OUT_PASS, KIND_CHAR, 8'h41, 16'h0000, 0, 0, 0, 0, 0, 0));
      // digit at the start of a stream is not a number
      table_row(KIND_CHAR, 8'h37, 16'h0001, 1'b0, 1'b1,
         make_result(OUT_PASS, KIND_CHAR, 8'h37, 16'h0001, 0, 0, 0, 0, 0, 0));
      table_row(KIND_BLANK, 8'hFF, 16'hFFFF, 1'b0, 1'b1,
         make_result(OUT_PASS, KIND_BLANK, 8'h00, 16'hFFFF, 0, 0, 0, 0, 0, 0));
      table_row(KIND_CHAR, CHAR_MINUS, 16'h1234, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h34, 16'h0002, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h32, 16'h0003, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_POINT, 16'h0004, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h35, 16'h0005, 1'b0, 1'b0, '0);
      // second point closes the number and goes through
      table_row(KIND_CHAR, CHAR_POINT, 16'h0055, 1'b0, 1'b0, '0);
      table_row(KIND_STRING, CHAR_MINUS, 16'h0101, 1'b0, 1'b1,
         make_result(OUT_PASS, KIND_STRING, 8'h00, 16'h0101, 0, 0, 0, 0, 0, 0));
      // lone minus
      table_row(KIND_CHAR, CHAR_MINUS, 16'h00AA, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h78, 16'h0BBB, 1'b0, 1'b0, '0);
      // point followed by a non-digit
      table_row(KIND_CHAR, CHAR_LPAREN, 16'h0006, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_ZERO, 16'h0007, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_POINT, 16'h0008, 1'b0, 1'b0, '0);
      table_row(KIND_OTHER, 8'h35, 16'h8000, 1'b0, 1'b0, '0);
      // trailing point at end of stream
      table_row(KIND_CHAR, CHAR_LBRACK, 16'h0009, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h38, 16'h000A, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_POINT, 16'h000B, 1'b1, 1'b1,
         make_result(OUT_NUMBER, KIND_CHAR, 8'h00, 16'h0000, 0, 8, 0, 0, 1, 1));
      // new stream after the end; held minus flushed at the end
      table_row(KIND_CHAR, CHAR_LBRACE, 16'h000C, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_MINUS, 16'h00C3, 1'b1, 1'b1,
         make_result(OUT_PASS, KIND_CHAR, CHAR_MINUS, 16'h00C3, 0, 0, 0, 0, 1, 0));
      table_row(KIND_CHAR, CHAR_RPAREN, 16'h000D, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, CHAR_MINUS, 16'h000E, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h39, 16'h000F, 1'b0, 1'b0, '0);
      table_row(KIND_CHAR, 8'h33, 16'h0010, 1'b1, 1'b1,
         make_result(OUT_NUMBER, KIND_CHAR, 8'h00, 16'h0000, 1, 93, 0, 0, 1, 0));
      table_row(KIND_OTHER, 8'h00, 16'hFFFF, 1'b1, 1'b1,
         make_result(OUT_PASS, KIND_OTHER, 8'h00, 16'hFFFF, 0, 0, 0, 0, 1, 0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 70;
      foreach (directed_table[i])
         send_symbol(directed_table[i].kind, directed_table[i].ch, directed_table[i].id,
            directed_table[i].eoi, directed_table[i].by_hand, directed_table[i].hand);
      while (symbols_sent < 700) send_random_segment();
      drain_results();

      send_idle_pct = 70;
      recv_idle_pct = 20;
      while (symbols_sent < 1400) send_random_segment();
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // receiver goes quiet for a long stretch while symbols keep coming
      hold_request = 1'b1;
      while (symbols_sent < 2000) send_random_segment();
      drain_results();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sdnl_pkg.sv
rtl/sdnl_core.sv
rtl/signed_decimal_number_lexer_top.sv
tb/sv/tb_top.sv
